// ===== hdl/cbpp_pkg.sv =====
// Shared types and constants for the cubic Bezier path point block.
`default_nettype none
package cbpp_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int COUNT_W   = 7;
  localparam int NUM_CH    = 4;
  localparam int COORD_W   = 32;
  localparam int PARAM_W   = 22;
  localparam int FRAC_W    = 16;
  localparam int T_W       = FRAC_W + 1;
  localparam int W_W       = 25;
  localparam int CP_W      = 36;
  localparam int PROD_W    = CP_W + W_W;
  localparam int SUM_W     = PROD_W + 2;

  localparam logic [COUNT_W-1:0] NODE_LIMIT  = COUNT_W'(MAX_NODES);
  localparam logic [T_W-1:0]     T_ONE       = T_W'(1 << FRAC_W);
  localparam logic [COORD_W-1:0] FOV_DEFAULT = 32'h003C_0000;
  localparam logic [33:0]        DIV3_M      = 34'd11453246123;

  // register map, word index taken from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [IDX_W-1:0]          node_index;
    logic signed [COORD_W-1:0] node_x;
    logic signed [COORD_W-1:0] node_y;
    logic signed [COORD_W-1:0] node_z;
    logic signed [COORD_W-1:0] node_fov;
    logic [PARAM_W-1:0]        path_param;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] point_fov;
  } out_beat_t;

  // channel 0 = x, 1 = y, 2 = z, 3 = fov
  typedef logic [NUM_CH-1:0][COORD_W-1:0] node_t;

endpackage
`default_nettype wire

// ===== hdl/cbpp_node_mem.sv =====
// Node table copy: one write port, one registered read port.
`default_nettype none
module cbpp_node_mem (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [cbpp_pkg::IDX_W-1:0]   wr_addr,
  input  cbpp_pkg::node_t              wr_data,
  input  logic [cbpp_pkg::IDX_W-1:0]   rd_addr,
  output cbpp_pkg::node_t              rd_data
);
  import cbpp_pkg::*;

  node_t mem [MAX_NODES];
  node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/cbpp_weights.sv =====
// Bernstein basis weights in Q1.24, two register stages.
`default_nettype none
module cbpp_weights (
  input  logic                                       clk,
  input  logic [cbpp_pkg::T_W-1:0]                   t_i,
  output logic [cbpp_pkg::NUM_CH-1:0][cbpp_pkg::W_W-1:0] w_o
);
  import cbpp_pkg::*;

  logic [T_W-1:0]   u_c;
  logic [T_W-1:0]   u_r, t_r;
  logic [2*T_W-1:0] uu_r, ut_r, tt_r;
  logic [NUM_CH-1:0][W_W-1:0] w_r;
  logic [52:0] p0, p1, p2, p3;

  assign u_c = T_ONE - t_i;

  always_ff @(posedge clk) begin
    u_r  <= u_c;
    t_r  <= t_i;
    uu_r <= (2*T_W)'(u_c) * (2*T_W)'(u_c);
    ut_r <= (2*T_W)'(u_c) * (2*T_W)'(t_i);
    tt_r <= (2*T_W)'(t_i) * (2*T_W)'(t_i);
  end

  always_comb begin
    p0 = 53'(uu_r) * 53'(u_r);
    p1 = 53'(uu_r) * 53'(t_r) * 53'd3;
    p2 = 53'(ut_r) * 53'(t_r) * 53'd3;
    p3 = 53'(tt_r) * 53'(t_r);
  end

  always_ff @(posedge clk) begin
    w_r[0] <= p0[48:24];
    w_r[1] <= p1[48:24];
    w_r[2] <= p2[48:24];
    w_r[3] <= p3[48:24];
  end

  assign w_o = w_r;

endmodule
`default_nettype wire

// ===== hdl/cbpp_channel.sv =====
// One coordinate channel: control points, weighted sum, floor divide, saturate.
`default_nettype none
module cbpp_channel (
  input  logic                                           clk,
  input  logic [cbpp_pkg::COORD_W-1:0]                   pm1_i,
  input  logic [cbpp_pkg::COORD_W-1:0]                   p0_i,
  input  logic [cbpp_pkg::COORD_W-1:0]                   p1_i,
  input  logic [cbpp_pkg::COORD_W-1:0]                   p2_i,
  input  logic                                           first_i,
  input  logic                                           last_i,
  input  logic [cbpp_pkg::NUM_CH-1:0][cbpp_pkg::W_W-1:0] w_i,
  output logic [cbpp_pkg::COORD_W-1:0]                   res_o
);
  import cbpp_pkg::*;

  localparam int V_W = SUM_W - 24;
  localparam logic signed [V_W-1:0] LIM = V_W'(64'sd12884901888); // 6 * 2^31

  logic signed [CP_W-1:0] am1, a0, a1, a2, six0, six1;
  logic signed [CP_W-1:0] c_nxt [NUM_CH];
  logic signed [CP_W-1:0] c_r   [NUM_CH];
  logic signed [CP_W-1:0] cd_r  [NUM_CH];
  logic signed [PROD_W-1:0] prod_r [NUM_CH];
  logic signed [SUM_W-1:0] sum_r;
  logic signed [V_W-1:0] v, x;
  logic [33:0] y_r;
  logic sat_hi_r, sat_lo_r, sat_hi_d_r, sat_lo_d_r;
  logic [50:0] pph_r, ppl_r;
  logic [67:0] full;
  logic [31:0] q;
  logic [COORD_W-1:0] res_r;

  always_comb begin
    am1  = CP_W'($signed(pm1_i));
    a0   = CP_W'($signed(p0_i));
    a1   = CP_W'($signed(p1_i));
    a2   = CP_W'($signed(p2_i));
    six0 = a0 * CP_W'(6);
    six1 = a1 * CP_W'(6);
    c_nxt[0] = six0;
    c_nxt[1] = first_i ? six0 + ((a1 - a0) <<< 1) : six0 + (a1 - am1);
    c_nxt[2] = last_i  ? six1 - ((a1 - a0) <<< 1) : six1 - (a2 - a0);
    c_nxt[3] = six1;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CH; k++) begin
      c_r[k]    <= c_nxt[k];
      cd_r[k]   <= c_r[k];
      prod_r[k] <= PROD_W'(cd_r[k]) * PROD_W'($signed({1'b0, w_i[k]}));
    end
    sum_r <= SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]);
  end

  // floor(sum / (6 * 2^24)): arithmetic shift, offset to non-negative, halve, divide by 3
  always_comb begin
    v = sum_r[SUM_W-1:24];
    x = v + LIM;
  end

  always_ff @(posedge clk) begin
    sat_hi_r   <= v >= LIM;
    sat_lo_r   <= v < -LIM;
    y_r        <= x[34:1];
    pph_r      <= 51'(y_r[33:17]) * 51'(DIV3_M);
    ppl_r      <= 51'(y_r[16:0]) * 51'(DIV3_M);
    sat_hi_d_r <= sat_hi_r;
    sat_lo_d_r <= sat_lo_r;
  end

  always_comb begin
    full = {pph_r, 17'b0} + 68'(ppl_r);
    q    = full[66:35];
  end

  always_ff @(posedge clk) begin
    if (sat_hi_d_r) begin
      res_r <= 32'h7FFF_FFFF;
    end else if (sat_lo_d_r) begin
      res_r <= 32'h8000_0000;
    end else begin
      res_r <= {~q[31], q[30:0]};
    end
  end

  assign res_o = res_r;

endmodule
`default_nettype wire

// ===== hdl/cubic_bezier_path_point.sv =====
// Top level of the cubic Bezier path point block.
// Takes one beat per cycle (busy is always low) and returns the point of an
// evaluate beat on out_valid once it has passed the pipeline; write beats
// give no result. out_valid is a one-cycle strobe: the receiver cannot hold
// a result off, so it must take every beat as it comes. The latency is set
// by the multiply chain: basis weights, control point times weight, and the
// reciprocal divide by six. A write is visible to an evaluate beat accepted
// in the next cycle. Node slots are undefined until written; configure
// node_count only while no result is due.
`default_nettype none
module cubic_bezier_path_point (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cbpp_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  output cbpp_pkg::out_beat_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cbpp_pkg::*;

  localparam int DEPTH = 7;

  typedef struct packed {
    logic               valid;
    logic               few;
    logic               n_any;
    logic [COORD_W-1:0] fov0;
  } side_t;

  logic [COUNT_W-1:0] node_count_r;
  logic accept, wr_en, ev_en;

  logic [COUNT_W-1:0] n;
  logic [IDX_W-1:0]   seg, s;
  logic [T_W-1:0]     t;
  logic few, n_any, first, last;

  logic               v1_r, few_r, n_any_r, first_r, last_r;
  logic [T_W-1:0]     t_r;

  node_t wr_node;
  node_t rd_m1, rd_0, rd_1, rd_2;
  logic [NUM_CH-1:0][W_W-1:0] w;
  logic [NUM_CH-1:0][COORD_W-1:0] res;

  side_t side_r [DEPTH];
  logic  out_valid_r;
  out_beat_t out_data_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign wr_en  = accept && (in_data.op == OP_WRITE);
  assign ev_en  = accept && (in_data.op == OP_EVAL);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NODE_COUNT) begin
      node_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_r) : '0;

  // segment select and clamp
  always_comb begin
    n     = (node_count_r > NODE_LIMIT) ? NODE_LIMIT : node_count_r;
    few   = n < COUNT_W'(2);
    n_any = n != '0;
    seg   = in_data.path_param[PARAM_W-1:FRAC_W];
    if (few) begin
      s = '0;
      t = '0;
    end else if (COUNT_W'(seg) >= n - COUNT_W'(1)) begin
      s = IDX_W'(n - COUNT_W'(2));
      t = T_ONE;
    end else begin
      s = seg;
      t = T_W'(in_data.path_param[FRAC_W-1:0]);
    end
    first = s == '0;
    last  = COUNT_W'(s) + COUNT_W'(2) >= n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= ev_en;
    end
    few_r   <= few;
    n_any_r <= n_any;
    first_r <= first;
    last_r  <= last;
    t_r     <= t;
  end

  assign wr_node = {in_data.node_fov, in_data.node_z, in_data.node_y, in_data.node_x};

  cbpp_node_mem u_mem_m1 (.clk, .wr_en, .wr_addr(in_data.node_index), .wr_data(wr_node),
                          .rd_addr(s - IDX_W'(1)), .rd_data(rd_m1));
  cbpp_node_mem u_mem_0  (.clk, .wr_en, .wr_addr(in_data.node_index), .wr_data(wr_node),
                          .rd_addr(s), .rd_data(rd_0));
  cbpp_node_mem u_mem_1  (.clk, .wr_en, .wr_addr(in_data.node_index), .wr_data(wr_node),
                          .rd_addr(s + IDX_W'(1)), .rd_data(rd_1));
  cbpp_node_mem u_mem_2  (.clk, .wr_en, .wr_addr(in_data.node_index), .wr_data(wr_node),
                          .rd_addr(s + IDX_W'(2)), .rd_data(rd_2));

  cbpp_weights u_weights (.clk, .t_i(t_r), .w_o(w));

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    cbpp_channel u_channel (
      .clk,
      .pm1_i  (rd_m1[ch]),
      .p0_i   (rd_0[ch]),
      .p1_i   (rd_1[ch]),
      .p2_i   (rd_2[ch]),
      .first_i(first_r),
      .last_i (last_r),
      .w_i    (w),
      .res_o  (res[ch])
    );
  end

  // side band travels alongside the channel pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else begin
      side_r[0].valid <= v1_r;
      for (int i = 1; i < DEPTH; i++) begin
        side_r[i].valid <= side_r[i-1].valid;
      end
    end
    side_r[0].few   <= few_r;
    side_r[0].n_any <= n_any_r;
    side_r[0].fov0  <= rd_0[3];
    for (int i = 1; i < DEPTH; i++) begin
      side_r[i].few   <= side_r[i-1].few;
      side_r[i].n_any <= side_r[i-1].n_any;
      side_r[i].fov0  <= side_r[i-1].fov0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_r[DEPTH-1].valid;
    end
    if (side_r[DEPTH-1].few) begin
      out_data_r.point_x   <= '0;
      out_data_r.point_y   <= '0;
      out_data_r.point_z   <= '0;
      out_data_r.point_fov <= side_r[DEPTH-1].n_any ? side_r[DEPTH-1].fov0 : FOV_DEFAULT;
    end else begin
      out_data_r.point_x   <= res[0];
      out_data_r.point_y   <= res[1];
      out_data_r.point_z   <= res[2];
      out_data_r.point_fov <= res[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/cbpp_checker.sv =====
// Checker for the cubic Bezier path point block: predicts each point and compares.
`timescale 1ns / 1ps
module cbpp_checker
  import cbpp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  in_beat_t            in_data,
  input  logic                out_valid,
  input  out_beat_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  errors,
  output int                  pending
);

  localparam longint DEN = 64'sd6 * 64'sd16777216;

  longint                node_mem [MAX_NODES][NUM_CH];
  logic [COUNT_W-1:0]    count_reg;
  out_beat_t             points_due [$];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint bezier_ch(int ch, int s, int n, longint w[4]);
    longint p0, p3, c1, c2, sum, q;
    p0 = node_mem[s][ch];
    p3 = node_mem[s+1][ch];
    if (s == 0) c1 = 6 * p0 + 2 * (p3 - p0);
    else c1 = 6 * p0 + (p3 - node_mem[s-1][ch]);
    if (s + 2 >= n) c2 = 6 * p3 - 2 * (p3 - p0);
    else c2 = 6 * p3 - (node_mem[s+2][ch] - p0);
    sum = 6 * p0 * w[0] + c1 * w[1] + c2 * w[2] + 6 * p3 * w[3];
    q = sum / DEN;
    if ((sum % DEN) != 0 && sum < 0) q--;
    return q;
  endfunction

  function automatic out_beat_t path_point(logic [PARAM_W-1:0] param);
    out_beat_t           pt;
    int                  n, s;
    longint unsigned     t, u;
    longint              w[4];
    longint              v[NUM_CH];
    n = (count_reg > NODE_LIMIT) ? MAX_NODES : int'(count_reg);
    if (n < 2) begin
      pt.point_x   = '0;
      pt.point_y   = '0;
      pt.point_z   = '0;
      pt.point_fov = (n == 0) ? FOV_DEFAULT : clamp32(node_mem[0][3]);
      return pt;
    end
    s = int'(param >> FRAC_W);
    t = param[FRAC_W-1:0];
    // past the end: last node of the last segment
    if (s >= n - 1) begin
      s = n - 2;
      t = 65536;
    end
    u = 65536 - t;
    w[0] = longint'((u * u * u) >> 24);
    w[1] = longint'((3 * u * u * t) >> 24);
    w[2] = longint'((3 * u * t * t) >> 24);
    w[3] = longint'((t * t * t) >> 24);
    for (int ch = 0; ch < NUM_CH; ch++) v[ch] = bezier_ch(ch, s, n, w);
    pt.point_x   = clamp32(v[0]);
    pt.point_y   = clamp32(v[1]);
    pt.point_z   = clamp32(v[2]);
    pt.point_fov = clamp32(v[3]);
    return pt;
  endfunction

  assign pending = points_due.size();

  always @(posedge clk) begin
    out_beat_t exp_pt;
    if (!rst_n) begin
      errors = 0;
      count_reg = '0;
      points_due.delete();
    end else begin
      if (out_valid) begin
        if (points_due.size() == 0) begin
          $error("unexpected result beat %h", out_data);
          errors++;
        end else begin
          exp_pt = points_due.pop_front();
          if (out_data.point_x !== exp_pt.point_x) begin
            $error("point_x exp %h got %h", exp_pt.point_x, out_data.point_x);
            errors++;
          end
          if (out_data.point_y !== exp_pt.point_y) begin
            $error("point_y exp %h got %h", exp_pt.point_y, out_data.point_y);
            errors++;
          end
          if (out_data.point_z !== exp_pt.point_z) begin
            $error("point_z exp %h got %h", exp_pt.point_z, out_data.point_z);
            errors++;
          end
          if (out_data.point_fov !== exp_pt.point_fov) begin
            $error("point_fov exp %h got %h", exp_pt.point_fov, out_data.point_fov);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (in_data.op == OP_EVAL) begin
          points_due.insert(points_due.size(), path_point(in_data.path_param));
        end else begin
          node_mem[in_data.node_index][0] = longint'(in_data.node_x);
          node_mem[in_data.node_index][1] = longint'(in_data.node_y);
          node_mem[in_data.node_index][2] = longint'(in_data.node_z);
          node_mem[in_data.node_index][3] = longint'(in_data.node_fov);
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_NODE_COUNT)
        count_reg = pwdata[COUNT_W-1:0];
    end
  end

endmodule

// ===== tb/tb_cubic_bezier_path_point.sv =====
// Testbench top for the cubic Bezier path point block: stimulus and verdict.
`timescale 1ns / 1ps
module tb_cubic_bezier_path_point;
  import cbpp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_beat_t    in_data = '0;
  logic        out_valid;
  out_beat_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          node_cnt = 0;
  bit          idle_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cubic_bezier_path_point u_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cbpp_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cubic_bezier_path_point regression: fail");
      $finish;
    end
  end

  // start stays high across back-to-back beats
  task automatic send(in_beat_t b);
    bit ok;
    in_data <= b;
    start   <= 1'b1;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(int v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'({REG_NODE_COUNT, 2'b00});
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    node_cnt = (v > MAX_NODES) ? MAX_NODES : v;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t node_wr(int idx, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z, logic [31:0] f);
    in_beat_t b;
    b = '0;
    b.op = OP_WRITE;
    b.node_index = IDX_W'(idx);
    b.node_x = x;
    b.node_y = y;
    b.node_z = z;
    b.node_fov = f;
    b.path_param = PARAM_W'($urandom);
    return b;
  endfunction

  function automatic in_beat_t eval_at(logic [PARAM_W-1:0] p);
    in_beat_t b;
    b = '0;
    b.op = OP_EVAL;
    b.node_index = IDX_W'($urandom);
    b.node_x = $urandom;
    b.node_y = $urandom;
    b.node_z = $urandom;
    b.node_fov = $urandom;
    b.path_param = p;
    return b;
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param();
    int r, seg;
    r = $urandom_range(0, 9);
    if (node_cnt < 2 || r >= 8) return PARAM_W'($urandom);
    if (r == 7) seg = $urandom_range(node_cnt - 1, 63);
    else seg = $urandom_range(0, node_cnt - 2);
    if (r == 6) return {6'(seg), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
    return {6'(seg), 16'($urandom)};
  endfunction

  task automatic random_phase(int count, int items, bit no_idle, bit mid_pause);
    set_count(count);
    idle_on = !no_idle;
    for (int i = 0; i < items; i++) begin
      maybe_idle();
      if (mid_pause && i == items / 2) settle();
      if ($urandom_range(0, 3) == 0)
        send(node_wr($urandom_range(0, 63), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord()));
      else
        send(eval_at(rand_param()));
    end
    idle_on = 1'b1;
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no nodes: default field of view
    send(eval_at('0));
    send(eval_at('1));
    // fill every slot, first few at the extremes
    send(node_wr(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF));
    send(node_wr(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
    send(node_wr(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h003C_0000));
    for (int i = 3; i < MAX_NODES; i++)
      send(node_wr(i, pick_coord(), pick_coord(), pick_coord(), pick_coord()));
    settle();

    // single node: zero position, node 0 fov
    set_count(1);
    send(eval_at(22'h00_8000));
    settle();

    set_count(2);
    send(eval_at(22'h00_0000));
    send(eval_at(22'h00_8000));
    send(eval_at(22'h00_FFFF));
    send(eval_at(22'h01_0000));
    send(eval_at(22'h3F_FFFF));
    settle();

    set_count(64);
    send(eval_at(22'h00_4000));
    send(eval_at(22'h01_8000));
    send(eval_at(22'h3E_8000));
    send(eval_at(22'h3F_0000));
    settle();

    random_phase(2, 240, 1'b0, 1'b1);
    random_phase(64, 240, 1'b0, 1'b0);
    random_phase(3, 240, 1'b0, 1'b0);
    random_phase(127, 240, 1'b0, 1'b0);
    random_phase(64, 240, 1'b1, 1'b0);
    random_phase(5, 200, 1'b0, 1'b0);
    random_phase($urandom_range(0, 127), 200, 1'b0, 1'b0);
    random_phase($urandom_range(0, 127), 200, 1'b0, 1'b0);
    random_phase(0, 40, 1'b0, 1'b0);

    if (pending != 0) $error("%0d expected points never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("cubic_bezier_path_point regression: pass");
    end else begin
      $display("cubic_bezier_path_point regression: fail");
    end
    $finish;
  end

endmodule
